@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Each macro is compiled out when NO_ASSERTIONS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/lbc_pkg.sv @@
package lbc_pkg;

	// table geometry
	localparam int ENTRIES       = 16;
	localparam int PAYLOAD_WIDTH = 64;
	localparam int IDX_W         = $clog2(ENTRIES);
	localparam int CNT_W         = $clog2(ENTRIES + 1);

	// command codes
	typedef enum logic [2:0] {
		CMD_LOOKUP      = 3'd0,
		CMD_PUT         = 3'd1,
		CMD_DIRTY_FIRST = 3'd2,
		CMD_DIRTY_NEXT  = 3'd3,
		CMD_EVICT       = 3'd4
	} cmd_t;

	// request transaction
	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] node_in;
		logic [63:0] data_in;
		logic        mark_dirty;
	} req_t;

	// response transaction
	typedef struct packed {
		logic        ok;
		logic [31:0] node_out;
		logic [63:0] data_out;
		logic        dirty_out;
		logic [4:0]  occupancy;
	} rsp_t;

	// one stored entry (valid and dirty live in flops)
	typedef struct packed {
		logic [31:0]              node;
		logic [PAYLOAD_WIDTH-1:0] payload;
		logic [31:0]              use_stamp;
		logic [31:0]              order_stamp;
	} entry_t;

	// control from sequencer to scan unit
	typedef struct packed {
		logic       start;
		logic       cmp_vld;
		logic       load_min;
		logic [2:0] op;
	} scan_ctl_t;

	// scan outcome
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		logic             dirty;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
		entry_t           word;
	} scan_res_t;

endpackage

@@ hw/rtl/lru_block_cache_table_unit.sv @@
// Fully associative write-back block cache of ENTRIES entries keyed by node.
// Request channel (req_valid/req_ready/req) carries a command, node, payload
// and dirty mark; response channel (rsp_valid/rsp_ready/rsp) returns exactly
// one transaction per request: ok, node, payload, dirty mark, occupancy.
// Commands: lookup, put, dirty first, dirty next, evict least recently used.
// One request is handled at a time. A sequencer sweeps the entry RAM one
// entry per cycle through a single shared compare/age-subtract unit for
// lookup, put, dirty first and evict; dirty next first reads the cursor entry
// and loads its age, then sweeps. Unused codes, and dirty next with no
// cursor, skip the sweep and go straight to the decide state. The next
// request can be accepted once the response is registered.
// Reset clears all valid and dirty marks, both stamp counters, the dirty
// cursor and the occupancy count; entry RAM contents need no clearing.
// A response waiting on rsp_ready is held in the output register; a finished
// request waits for that register before it updates the table.
module lru_block_cache_table_unit import lbc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	`include "assert_macros.svh"

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_CUR_RD  = 5'b00010,
		ST_CUR_AGE = 5'b00100,
		ST_SCAN    = 5'b01000,
		ST_DECIDE  = 5'b10000
	} state_t;

	state_t state_q;

	// captured request
	logic [2:0]               cmd_q;
	logic [31:0]              node_q;
	logic [PAYLOAD_WIDTH-1:0] data_q;
	logic                     mark_q;

	// table control state
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] dirty_q;
	logic [31:0]        use_cnt_q;
	logic [31:0]        ord_cnt_q;
	logic [IDX_W-1:0]   cursor_q;
	logic               cursor_valid_q;
	logic [CNT_W-1:0]   count_q;

	// sweep counter and compare stage
	logic [IDX_W:0]   scan_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic             accept;
	logic             commit;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_word;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_word;
	scan_ctl_t        ctl;
	scan_res_t        res;
	rsp_t             rsp_d;
	logic             put_hit;
	logic             scan_last;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign commit    = (state_q == ST_DECIDE) && (!rsp_valid_q || rsp_ready);
	assign scan_last = (scan_q == (IDX_W + 1)'(ENTRIES));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SCAN) && !scan_last;
			case (state_q)
				ST_IDLE: begin
					scan_q <= '0;
					if (accept) begin
						case (req.cmd)
							CMD_DIRTY_NEXT: begin
								state_q <= cursor_valid_q ? ST_CUR_RD : ST_DECIDE;
							end
							CMD_LOOKUP, CMD_PUT, CMD_DIRTY_FIRST, CMD_EVICT: begin
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_DECIDE;
							end
						endcase
					end
				end
				ST_CUR_RD: begin
					state_q <= ST_CUR_AGE;
				end
				ST_CUR_AGE: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture and compare-stage index
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.cmd;
			node_q <= req.node_in;
			data_q <= req.data_in[PAYLOAD_WIDTH-1:0];
			mark_q <= req.mark_dirty;
		end
		cmp_idx_s1 <= scan_q[IDX_W-1:0];
	end

	// RAM read address
	assign rd_addr = (state_q == ST_CUR_RD) ? cursor_q : scan_q[IDX_W-1:0];

	lbc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_word),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	// scan unit control
	assign ctl.start    = accept;
	assign ctl.cmp_vld  = cmp_vld_s1;
	assign ctl.load_min = (state_q == ST_CUR_AGE);
	assign ctl.op       = cmd_q;

	lbc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.idx       (cmp_idx_s1),
		.word      (rd_word),
		.ent_valid (valid_q[cmp_idx_s1]),
		.ent_dirty (dirty_q[cmp_idx_s1]),
		.key       (node_q),
		.use_cnt   (use_cnt_q),
		.ord_cnt   (ord_cnt_q),
		.res       (res)
	);

	assign put_hit = res.found || res.free_found;

	// response, occupancy and entry write for the finished request
	always_comb begin
		logic             wr_req;
		logic [CNT_W-1:0] next_count;
		wr_req          = 1'b0;
		wr_addr         = res.idx;
		wr_word         = res.word;
		rsp_d.ok        = 1'b0;
		rsp_d.node_out  = '0;
		rsp_d.data_out  = '0;
		rsp_d.dirty_out = 1'b0;
		case (cmd_q)
			CMD_LOOKUP: begin
				if (res.found) begin
					wr_req              = 1'b1;
					wr_word.use_stamp   = use_cnt_q;
					wr_word.order_stamp = ord_cnt_q;
					rsp_d.ok            = 1'b1;
					rsp_d.node_out      = res.word.node;
					rsp_d.data_out      = 64'(res.word.payload);
				end
			end
			CMD_PUT: begin
				wr_req            = put_hit;
				wr_addr           = res.found ? res.idx : res.free_idx;
				wr_word.node      = node_q;
				wr_word.payload   = data_q;
				wr_word.use_stamp = use_cnt_q;
				if (!res.found) begin
					wr_word.order_stamp = ord_cnt_q;
				end
				rsp_d.ok = put_hit;
			end
			CMD_DIRTY_FIRST, CMD_DIRTY_NEXT: begin
				if (res.found) begin
					rsp_d.ok       = 1'b1;
					rsp_d.node_out = res.word.node;
					rsp_d.data_out = 64'(res.word.payload);
				end
			end
			CMD_EVICT: begin
				if (res.found) begin
					rsp_d.ok        = 1'b1;
					rsp_d.node_out  = res.word.node;
					rsp_d.data_out  = 64'(res.word.payload);
					rsp_d.dirty_out = res.dirty;
				end
			end
			default: begin
				wr_req = 1'b0;
			end
		endcase
		wr_en = commit && wr_req;

		// occupancy after the update
		next_count = count_q;
		if ((cmd_q == CMD_PUT) && !res.found && res.free_found) begin
			next_count = count_q + 1'b1;
		end else if ((cmd_q == CMD_EVICT) && res.found) begin
			next_count = count_q - 1'b1;
		end
		rsp_d.occupancy = 5'(next_count);
	end

	// table control state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			dirty_q        <= '0;
			use_cnt_q      <= '0;
			ord_cnt_q      <= '0;
			cursor_q       <= '0;
			cursor_valid_q <= 1'b0;
			count_q        <= '0;
		end else if (commit) begin
			count_q <= CNT_W'(rsp_d.occupancy);
			case (cmd_q)
				CMD_LOOKUP: begin
					if (res.found) begin
						use_cnt_q <= use_cnt_q + 1'b1;
						ord_cnt_q <= ord_cnt_q + 1'b1;
					end
				end
				CMD_PUT: begin
					cursor_valid_q <= 1'b0;
					if (res.found) begin
						dirty_q[res.idx] <= res.dirty | mark_q;
						use_cnt_q        <= use_cnt_q + 1'b1;
					end else if (res.free_found) begin
						valid_q[res.free_idx] <= 1'b1;
						dirty_q[res.free_idx] <= mark_q;
						use_cnt_q             <= use_cnt_q + 1'b1;
						ord_cnt_q             <= ord_cnt_q + 1'b1;
					end
				end
				CMD_DIRTY_FIRST, CMD_DIRTY_NEXT: begin
					cursor_valid_q <= res.found;
					if (res.found) begin
						cursor_q <= res.idx;
					end
				end
				CMD_EVICT: begin
					if (res.found) begin
						valid_q[res.idx] <= 1'b0;
						dirty_q[res.idx] <= 1'b0;
						if (cursor_valid_q && (cursor_q == res.idx)) begin
							cursor_valid_q <= 1'b0;
						end
					end
				end
				default: begin
					cursor_valid_q <= cursor_valid_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// occupancy count tracks the valid marks
	`ASSERT_CLK(a_count_matches_valid, clk, arst_n, CNT_W'($countones(valid_q)) == count_q)
	// the dirty cursor always points at a valid dirty entry
	`ASSERT_IMP(a_cursor_on_dirty, clk, arst_n, cursor_valid_q, valid_q[cursor_q] && dirty_q[cursor_q])
	// an accepted transaction leaves the idle state
	`ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE)
	// the table is only updated when the output register can take the response
	`ASSERT_IMP(a_commit_slot_free, clk, arst_n, wr_en, !rsp_valid_q || rsp_ready)

endmodule

@@ hw/rtl/lbc_ram.sv @@
module lbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ hw/rtl/lbc_scan.sv @@
module lbc_scan import lbc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  scan_ctl_t        ctl,
	input  logic [IDX_W-1:0] idx,
	input  entry_t           word,
	input  logic             ent_valid,
	input  logic             ent_dirty,
	input  logic [31:0]      key,
	input  logic [31:0]      use_cnt,
	input  logic [31:0]      ord_cnt,
	output scan_res_t        res
);

	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [31:0]      best_age_q;
	logic             best_dirty_q;
	entry_t           best_word_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [31:0]      min_age_q;

	logic [31:0] age;
	logic        take;

	// shared age subtractor: use age for eviction, order age otherwise
	always_comb begin
		if (ctl.op == CMD_EVICT) begin
			age = use_cnt - word.use_stamp;
		end else begin
			age = ord_cnt - word.order_stamp;
		end
	end

	// candidate test for the entry on the compare stage
	always_comb begin
		case (ctl.op)
			CMD_LOOKUP, CMD_PUT: begin
				take = ent_valid && (word.node == key) && !found_q;
			end
			CMD_DIRTY_FIRST: begin
				take = ent_valid && ent_dirty && (!found_q || (age < best_age_q));
			end
			CMD_DIRTY_NEXT: begin
				take = ent_valid && ent_dirty && (age > min_age_q)
					&& (!found_q || (age < best_age_q));
			end
			CMD_EVICT: begin
				take = ent_valid && (!found_q || (age > best_age_q));
			end
			default: begin
				take = 1'b0;
			end
		endcase
		take = take && ctl.cmp_vld;
	end

	// flags of the running search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (take) begin
				found_q <= 1'b1;
			end
			if (ctl.cmp_vld && !ent_valid) begin
				free_found_q <= 1'b1;
			end
		end
	end

	// best candidate, lowest free slot and cursor age
	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q   <= idx;
			best_age_q   <= age;
			best_dirty_q <= ent_dirty;
			best_word_q  <= word;
		end
		if (ctl.cmp_vld && !ent_valid && !free_found_q) begin
			free_idx_q <= idx;
		end
		if (ctl.load_min) begin
			min_age_q <= age;
		end
	end

	assign res.found      = found_q;
	assign res.idx        = best_idx_q;
	assign res.dirty      = best_dirty_q;
	assign res.free_found = free_found_q;
	assign res.free_idx   = free_idx_q;
	assign res.word       = best_word_q;

endmodule

@@ tb/sv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lbc_pkg::*;

	localparam int RANDOM_OPS  = 1850;
	localparam int NODE_POOL   = 24;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 40;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	req_t req       = '0;
	logic req_ready;
	logic rsp_valid;
	rsp_t rsp;

	lru_block_cache_table_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// shadow copy of the cache contents
	logic                     c_valid [ENTRIES] = '{default: 1'b0};
	logic [31:0]              c_node  [ENTRIES] = '{default: '0};
	logic [PAYLOAD_WIDTH-1:0] c_data  [ENTRIES] = '{default: '0};
	logic                     c_dirty [ENTRIES] = '{default: 1'b0};
	logic [31:0]              c_use   [ENTRIES] = '{default: '0};
	logic [31:0]              c_order [ENTRIES] = '{default: '0};
	logic [31:0]              use_ctr   = '0;
	logic [31:0]              order_ctr = '0;
	int                       cur_idx   = 0;
	logic                     cur_vld   = 1'b0;
	int                       fill      = 0;

	req_t        ops_pending [$];
	rsp_t        replies_due [$];
	logic [31:0] node_pool [NODE_POOL];
	int unsigned send_gap_pct = 0;
	int unsigned stall_pct    = 0;
	int          mismatches   = 0;
	int          cycles       = 0;
	int          ops_by_cmd [8] = '{default: 0};
	int          ok_by_cmd  [8] = '{default: 0};
	int          full_puts  = 0;

	// lowest valid entry holding this node, or -1
	function automatic int find_node(input logic [31:0] n);
		int i;
		int k;
		k = -1;
		for (i = ENTRIES - 1; i >= 0; i--)
			if (c_valid[i] && c_node[i] == n)
				k = i;
		return k;
	endfunction

	// newest dirty entry, optionally strictly older than min_age
	function automatic int newest_dirty_entry(input logic has_min, input logic [31:0] min_age);
		int          i;
		int          best;
		logic [31:0] age;
		logic [31:0] best_age;
		best     = -1;
		best_age = '0;
		for (i = 0; i < ENTRIES; i++) begin
			if (c_valid[i] && c_dirty[i]) begin
				age = order_ctr - c_order[i];
				if (!(has_min && age <= min_age) && (best < 0 || age < best_age)) begin
					best     = i;
					best_age = age;
				end
			end
		end
		return best;
	endfunction

	// apply one transaction to the shadow cache, return the reply it should give
	function automatic rsp_t apply_cache_op(input req_t r);
		rsp_t        o;
		int          i;
		int          k;
		logic [31:0] age;
		logic [31:0] best_age;
		o        = '0;
		k        = -1;
		best_age = '0;
		case (r.cmd)
			CMD_LOOKUP: begin
				k = find_node(r.node_in);
				if (k >= 0) begin
					c_use[k]   = use_ctr;
					use_ctr    = use_ctr + 1;
					c_order[k] = order_ctr;
					order_ctr  = order_ctr + 1;
					o.ok       = 1'b1;
					o.node_out = c_node[k];
					o.data_out = 64'(c_data[k]);
				end
			end
			CMD_PUT: begin
				cur_vld = 1'b0;
				k = find_node(r.node_in);
				if (k < 0) begin
					for (i = ENTRIES - 1; i >= 0; i--)
						if (!c_valid[i])
							k = i;
					if (k >= 0) begin
						c_valid[k] = 1'b1;
						c_dirty[k] = 1'b0;
						c_order[k] = order_ctr;
						order_ctr  = order_ctr + 1;
						fill++;
					end
				end
				if (k >= 0) begin
					c_node[k] = r.node_in;
					c_use[k]  = use_ctr;
					use_ctr   = use_ctr + 1;
					if (r.mark_dirty)
						c_dirty[k] = 1'b1;
					c_data[k] = r.data_in[PAYLOAD_WIDTH-1:0];
					o.ok      = 1'b1;
				end
			end
			CMD_DIRTY_FIRST, CMD_DIRTY_NEXT: begin
				if (r.cmd == CMD_DIRTY_FIRST)
					k = newest_dirty_entry(1'b0, '0);
				else if (cur_vld)
					k = newest_dirty_entry(1'b1, order_ctr - c_order[cur_idx]);
				if (k >= 0) begin
					cur_idx    = k;
					cur_vld    = 1'b1;
					o.ok       = 1'b1;
					o.node_out = c_node[k];
					o.data_out = 64'(c_data[k]);
				end else begin
					cur_vld = 1'b0;
				end
			end
			CMD_EVICT: begin
				for (i = 0; i < ENTRIES; i++) begin
					if (c_valid[i]) begin
						age = use_ctr - c_use[i];
						if (k < 0 || age > best_age) begin
							k        = i;
							best_age = age;
						end
					end
				end
				if (k >= 0) begin
					o.ok        = 1'b1;
					o.node_out  = c_node[k];
					o.data_out  = 64'(c_data[k]);
					o.dirty_out = c_dirty[k];
					c_valid[k]  = 1'b0;
					c_dirty[k]  = 1'b0;
					if (fill > 0)
						fill--;
					if (cur_vld && cur_idx == k)
						cur_vld = 1'b0;
				end
			end
			default: begin
				// unused codes leave the cache alone
			end
		endcase
		o.occupancy = 5'(fill);
		return o;
	endfunction

	task automatic compare_reply(input rsp_t want, input rsp_t got);
		if (got.ok !== want.ok) begin
			$display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
			mismatches++;
		end
		if (got.node_out !== want.node_out) begin
			$display("%0t: node_out expected %h actual %h", $time, want.node_out, got.node_out);
			mismatches++;
		end
		if (got.data_out !== want.data_out) begin
			$display("%0t: data_out expected %h actual %h", $time, want.data_out, got.data_out);
			mismatches++;
		end
		if (got.dirty_out !== want.dirty_out) begin
			$display("%0t: dirty_out expected %0b actual %0b", $time, want.dirty_out,
				got.dirty_out);
			mismatches++;
		end
		if (got.occupancy !== want.occupancy) begin
			$display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
				got.occupancy);
			mismatches++;
		end
	endtask

	function automatic req_t cache_op(input logic [2:0] c, input logic [31:0] n,
		input logic [63:0] d, input logic m);
		req_t r;
		r.cmd        = c;
		r.node_in    = n;
		r.data_in    = d;
		r.mark_dirty = m;
		return r;
	endfunction

	// one op with random content, keys mostly from the pool so lookups and puts collide
	function automatic req_t random_cache_op();
		int          pick;
		logic [31:0] n;
		logic [63:0] d;
		logic        m;
		pick = $urandom_range(99);
		n    = ($urandom_range(9) == 0) ? 32'($urandom) : node_pool[$urandom_range(NODE_POOL - 1)];
		d    = {32'($urandom), 32'($urandom)};
		m    = 1'($urandom_range(1));
		if (pick < 34)
			return cache_op(CMD_PUT, n, d, m);
		else if (pick < 62)
			return cache_op(CMD_LOOKUP, n, d, m);
		else if (pick < 76)
			return cache_op(CMD_EVICT, n, d, m);
		else if (pick < 84)
			return cache_op(CMD_DIRTY_FIRST, n, d, m);
		else if (pick < 97)
			return cache_op(CMD_DIRTY_NEXT, n, d, m);
		else
			return cache_op(3'($urandom_range(7, 5)), n, d, m);
	endfunction

	// single ops, plus dirty walks: a first then a run of nexts with the odd op between
	task automatic queue_random_ops(input int target);
		int queued;
		int steps;
		int j;
		queued = 0;
		while (queued < target) begin
			if ($urandom_range(99) < 12) begin
				ops_pending.push_back(cache_op(CMD_DIRTY_FIRST, 32'($urandom),
					{32'($urandom), 32'($urandom)}, 1'($urandom_range(1))));
				steps = $urandom_range(6, 1);
				for (j = 0; j < steps; j++) begin
					if ($urandom_range(99) < 80)
						ops_pending.push_back(cache_op(CMD_DIRTY_NEXT, 32'($urandom),
							{32'($urandom), 32'($urandom)}, 1'($urandom_range(1))));
					else
						ops_pending.push_back(random_cache_op());
				end
				queued += steps + 1;
			end else begin
				ops_pending.push_back(random_cache_op());
				queued++;
			end
		end
	endtask

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (ops_pending.size() != 0 || req_valid || replies_due.size() != 0);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_ready) begin
				if (ops_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					req       <= ops_pending.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// monitor: check replies first, then predict for a newly accepted request
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: reply with none outstanding: %p", $time, rsp);
					mismatches++;
				end else begin
					compare_reply(replies_due.pop_front(), rsp);
				end
			end
			if (req_valid && req_ready) begin
				if (req.cmd == CMD_PUT && find_node(req.node_in) < 0 && fill == ENTRIES)
					full_puts++;
				want = apply_cache_op(req);
				replies_due.push_back(want);
				ops_by_cmd[req.cmd]++;
				if (want.ok)
					ok_by_cmd[req.cmd]++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: no progress after %0d cycles, %0d replies outstanding", $time,
				cycles, replies_due.size());
			$display("[lru_block_cache_table_unit] ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned gap_by_phase [4];
		int unsigned stall_by_phase [4];
		int          p;
		int          i;
		gap_by_phase   = '{0, 79, 0, 23};
		stall_by_phase = '{0, 0, 79, 23};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty cache corner cases, unused codes, extremes, dirty walk, evictions
		ops_pending.push_back(cache_op(CMD_LOOKUP, 32'h0, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(CMD_EVICT, 32'h0, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(CMD_DIRTY_FIRST, 32'h0, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(CMD_DIRTY_NEXT, 32'h0, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(3'd5, 32'hFFFF_FFFF, '1, 1'b1));
		ops_pending.push_back(cache_op(3'd6, 32'h0, '1, 1'b1));
		ops_pending.push_back(cache_op(3'd7, 32'hFFFF_FFFF, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(CMD_PUT, 32'h0, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(CMD_PUT, 32'hFFFF_FFFF, '1, 1'b1));
		ops_pending.push_back(cache_op(CMD_PUT, 32'h0, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1));
		ops_pending.push_back(cache_op(CMD_LOOKUP, 32'hFFFF_FFFF, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(CMD_PUT, 32'h0, 64'h5A5A_A5A5_F0F0_0F0F, 1'b0));
		ops_pending.push_back(cache_op(CMD_DIRTY_FIRST, 32'h0, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(CMD_DIRTY_NEXT, 32'h0, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(CMD_DIRTY_NEXT, 32'h0, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(CMD_DIRTY_FIRST, 32'h0, 64'h0, 1'b0));
		// LRU is node FFFF_FFFF, the cursor entry, so it goes and takes the cursor with it
		ops_pending.push_back(cache_op(CMD_EVICT, 32'h0, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(CMD_EVICT, 32'h0, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(CMD_DIRTY_NEXT, 32'h0, 64'h0, 1'b0));
		ops_pending.push_back(cache_op(CMD_LOOKUP, 32'hFFFF_FFFF, 64'h0, 1'b0));
		wait_quiet();

		// random phases, each started only once the previous has fully drained
		for (p = 0; p < 4; p++) begin
			for (i = 0; i < NODE_POOL; i++)
				node_pool[i] = 32'($urandom);
			send_gap_pct = gap_by_phase[p];
			stall_pct    = stall_by_phase[p];
			queue_random_ops(RANDOM_OPS / 4);
			wait_quiet();
		end

		send_gap_pct = 0;
		stall_pct    = 0;
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("ran %0d transactions: %0d of %0d lookups hit, %0d puts stored, %0d refused as full",
			ops_by_cmd[CMD_LOOKUP] + ops_by_cmd[CMD_PUT] + ops_by_cmd[CMD_DIRTY_FIRST] +
			ops_by_cmd[CMD_DIRTY_NEXT] + ops_by_cmd[CMD_EVICT] + ops_by_cmd[5] +
			ops_by_cmd[6] + ops_by_cmd[7], ok_by_cmd[CMD_LOOKUP], ops_by_cmd[CMD_LOOKUP],
			ok_by_cmd[CMD_PUT], full_puts);
		$display("dirty walk: %0d firsts found, %0d nexts found; %0d evictions; %0d unused codes",
			ok_by_cmd[CMD_DIRTY_FIRST], ok_by_cmd[CMD_DIRTY_NEXT], ok_by_cmd[CMD_EVICT],
			ops_by_cmd[5] + ops_by_cmd[6] + ops_by_cmd[7]);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("[lru_block_cache_table_unit] OK");
		else
			$display("[lru_block_cache_table_unit] ERROR");
		$finish;
	end

endmodule
